@@ hw/rtl/tlt_pkg.sv @@
package tlt_pkg;

  localparam int OCC_W = 7;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_LOCK   = 2'd1;
  localparam logic [1:0] OP_UNLOCK = 2'd2;
  localparam logic [1:0] OP_QUERY  = 2'd3;

  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] flow_id;
    logic [31:0] chunk_id;
  } in_req_t;

  typedef struct packed {
    logic             is_locked;
    logic             stored;
    logic             removed;
    logic [OCC_W-1:0] occupancy;
  } out_res_t;

  // broadcast control for the row of cells
  typedef struct packed {
    logic eval;
    logic sel_stale;
    logic shift;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/timed_lock_table_unit.sv @@
// timed lock table: ordered list of (flow, chunk) locks held in a row of cells,
// each stamped with the tick count at which it was taken.
// input channel in_valid/in_stall carries one request (opcode, flow_id, chunk_id);
// output channel out_valid/out_stall returns exactly one result per request.
// cfg_wr_en/cfg_wr_data set the timeout; write only while the block is idle.
// one request is in flight at a time; in_stall is high while it is worked on.
// steps from acceptance to out_valid:
//   tick              time advances, straight to the final state
//   lock              store into the first free cell if the table is not full
//   unlock            flag evaluation, then one compaction shift
//   query             flag evaluation, then a purge of S stale entries, one
//                     removal per cycle through the shifting row of cells
// the next request can be taken in the same cycle that out_valid rises.
// a result waiting in the output register under out_stall does not stop a new
// request from being taken; that request waits in its final state until the result is gone.
// reset (synchronous, rst_n low) empties the table, zeroes time and sets the
// timeout to 1000 ticks; no clearing pass is needed.
module timed_lock_table_unit #(
  parameter int TABLE_DEPTH = 64,
  parameter int TIME_BITS   = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tlt_pkg::in_req_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tlt_pkg::out_res_t  out_data,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_LOCK   = 7'b0000010,
    S_EVAL   = 7'b0000100,
    S_UNLOCK = 7'b0001000,
    S_PURGE  = 7'b0010000,
    S_QUERY  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t               state_r, state_nxt;
  tlt_pkg::in_req_t     req_r;
  logic [CW-1:0]        count_r, count_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [31:0]          timeout_r;
  logic                 locked_r, locked_nxt;
  logic                 stored_r, stored_nxt;
  logic                 removed_r, removed_nxt;
  logic                 out_valid_r, out_valid_nxt;
  tlt_pkg::out_res_t    out_r;
  tlt_pkg::cell_ctrl_t  ctrl;
  logic                 accept;
  logic                 not_full;

  logic [31:0]          c_flow  [TABLE_DEPTH+1];
  logic [31:0]          c_chunk [TABLE_DEPTH+1];
  logic [TIME_BITS-1:0] c_stamp [TABLE_DEPTH+1];
  logic                 c_match [TABLE_DEPTH+1];
  logic                 c_stale [TABLE_DEPTH+1];
  logic                 found   [TABLE_DEPTH+1];

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);
  assign not_full = (count_r < CW'(TABLE_DEPTH));

  assign found[0]             = 1'b0;
  assign c_flow[TABLE_DEPTH]  = '0;
  assign c_chunk[TABLE_DEPTH] = '0;
  assign c_stamp[TABLE_DEPTH] = '0;
  assign c_match[TABLE_DEPTH] = 1'b0;
  assign c_stale[TABLE_DEPTH] = 1'b0;

  always_comb begin
    ctrl.eval      = (state_r == S_EVAL);
    ctrl.sel_stale = (state_r == S_PURGE);
    ctrl.shift     = (state_r == S_UNLOCK) || (state_r == S_PURGE);
  end

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    tlt_cell #(
      .TIME_BITS(TIME_BITS)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .load      ((state_r == S_LOCK) && not_full && (count_r == CW'(k))),
      .live      (CW'(k) < count_r),
      .found_in  (found[k]),
      .found_out (found[k+1]),
      .key_flow  (req_r.flow_id),
      .key_chunk (req_r.chunk_id),
      .now       (now_r),
      .timeout   (timeout_r),
      .nb_flow   (c_flow[k+1]),
      .nb_chunk  (c_chunk[k+1]),
      .nb_stamp  (c_stamp[k+1]),
      .nb_match  (c_match[k+1]),
      .nb_stale  (c_stale[k+1]),
      .flow      (c_flow[k]),
      .chunk     (c_chunk[k]),
      .stamp     (c_stamp[k]),
      .match     (c_match[k]),
      .stale     (c_stale[k])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    now_nxt       = now_r;
    locked_nxt    = locked_r;
    stored_nxt    = stored_r;
    removed_nxt   = removed_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          locked_nxt  = 1'b0;
          stored_nxt  = 1'b0;
          removed_nxt = 1'b0;
          case (in_data.opcode)
            tlt_pkg::OP_TICK: begin
              now_nxt   = now_r + TIME_BITS'(1);
              state_nxt = S_DONE;
            end
            tlt_pkg::OP_LOCK: state_nxt = S_LOCK;
            default:          state_nxt = S_EVAL;
          endcase
        end
      end
      S_LOCK: begin
        if (not_full) begin
          count_nxt  = count_r + CW'(1);
          stored_nxt = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_EVAL: begin
        state_nxt = (req_r.opcode == tlt_pkg::OP_UNLOCK) ? S_UNLOCK : S_PURGE;
      end
      S_UNLOCK: begin
        if (found[TABLE_DEPTH]) begin
          count_nxt   = count_r - CW'(1);
          removed_nxt = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_PURGE: begin
        // one stale entry leaves per cycle until none is left
        if (found[TABLE_DEPTH]) begin
          count_nxt = count_r - CW'(1);
        end else begin
          state_nxt = S_QUERY;
        end
      end
      S_QUERY: begin
        locked_nxt = found[TABLE_DEPTH];
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      now_r       <= '0;
      timeout_r   <= tlt_pkg::TIMEOUT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      now_r       <= now_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    locked_r  <= locked_nxt;
    stored_r  <= stored_nxt;
    removed_r <= removed_nxt;
    if (accept) begin
      req_r <= in_data;
    end
    if ((state_r == S_DONE) && (!out_valid_r || !out_stall)) begin
      out_r.is_locked <= locked_r;
      out_r.stored    <= stored_r;
      out_r.removed   <= removed_r;
      out_r.occupancy <= tlt_pkg::OCC_W'(count_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ hw/rtl/tlt_cell.sv @@
module tlt_cell #(
  parameter int TIME_BITS = 48
) (
  input  logic                   clk,
  input  tlt_pkg::cell_ctrl_t    ctrl,
  input  logic                   load,
  input  logic                   live,
  input  logic                   found_in,
  output logic                   found_out,
  input  logic [31:0]            key_flow,
  input  logic [31:0]            key_chunk,
  input  logic [TIME_BITS-1:0]   now,
  input  logic [31:0]            timeout,
  input  logic [31:0]            nb_flow,
  input  logic [31:0]            nb_chunk,
  input  logic [TIME_BITS-1:0]   nb_stamp,
  input  logic                   nb_match,
  input  logic                   nb_stale,
  output logic [31:0]            flow,
  output logic [31:0]            chunk,
  output logic [TIME_BITS-1:0]   stamp,
  output logic                   match,
  output logic                   stale
);

  logic [31:0]          flow_r;
  logic [31:0]          chunk_r;
  logic [TIME_BITS-1:0] stamp_r;
  logic                 match_r;
  logic                 stale_r;
  logic [TIME_BITS-1:0] age;
  logic                 hit;

  assign age       = now - stamp_r;
  assign hit       = live & (ctrl.sel_stale ? stale_r : match_r);
  // at or beyond the first hit every cell pulls from its right neighbour
  assign found_out = found_in | hit;

  always_ff @(posedge clk) begin
    if (load) begin
      flow_r  <= key_flow;
      chunk_r <= key_chunk;
      stamp_r <= now;
    end else if (ctrl.shift && found_out) begin
      flow_r  <= nb_flow;
      chunk_r <= nb_chunk;
      stamp_r <= nb_stamp;
      match_r <= nb_match;
      stale_r <= nb_stale;
    end else if (ctrl.eval) begin
      match_r <= (flow_r == key_flow) && (chunk_r == key_chunk);
      stale_r <= age > TIME_BITS'(timeout);
    end
  end

  assign flow  = flow_r;
  assign chunk = chunk_r;
  assign stamp = stamp_r;
  assign match = match_r;
  assign stale = stale_r;

endmodule
